[rtl/assert_macros.svh]
// assertion macros used by the checker file of the block
// no dependencies; take in with `include before the module header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle, consequent in the next cycle
`define WBTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbts check failed");

// antecedent and consequent in the same cycle
`define WBTS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbts check failed");

`endif

[rtl/wbts_pkg.sv]
// types and constants of the white blob steering block
// no dependencies; used by every module of the block
package wbts_pkg;

   // fixed field widths
   localparam int WIDTH_BITS     = 13;
   localparam int LEVEL_BITS     = 8;
   localparam int SPEED_BITS     = 15;
   localparam int TURN_BITS      = 16;
   localparam int CNT_OUT_BITS   = 22;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   // quotient of the shared divider: value in 0..32768
   localparam int QUO_BITS  = 16;
   localparam int STEP_BITS = 4;

   // floor(3*x/10) = (x * 157287) >> 19 for every 15-bit x
   localparam logic [17:0] SCALE_MUL   = 18'd157287;
   localparam int          SCALE_SHIFT = 19;

   localparam logic [SPEED_BITS-1:0] SPEED_SAT = 15'h7FFF;

   // register reset values
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 13'd640;
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 8'd255;
   localparam logic [SPEED_BITS-1:0] SPEED_RESET = 15'd6553;

   // register indexes (word address)
   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_WHITE_LEVEL = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED   = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0]       linear_speed;
      logic signed [TURN_BITS-1:0] turn_rate;
      logic                        ball_seen;
      logic [CNT_OUT_BITS-1:0]     left_pixels;
      logic [CNT_OUT_BITS-1:0]     mid_pixels;
      logic [CNT_OUT_BITS-1:0]     right_pixels;
   } result_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] image_width;
      logic [LEVEL_BITS-1:0] white_level;
      logic [SPEED_BITS-1:0] max_forward_speed;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TURN_GO,
      S_TURN_WAIT,
      S_SPEED_GO,
      S_SPEED_WAIT,
      S_SCALE,
      S_DONE
   } seq_state_type;

endpackage

[rtl/wbts_csr.sv]
// configuration registers of the white blob steering block, apb-style port
// depends on wbts_pkg
module wbts_csr
   import wbts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] index;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_IMAGE_WIDTH: cfg_in.image_width       = csr_pwdata[WIDTH_BITS-1:0];
            CSR_WHITE_LEVEL: cfg_in.white_level       = csr_pwdata[LEVEL_BITS-1:0];
            CSR_MAX_SPEED:   cfg_in.max_forward_speed = csr_pwdata[SPEED_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width       <= WIDTH_RESET;
         cfg_ff.white_level       <= LEVEL_RESET;
         cfg_ff.max_forward_speed <= SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         CSR_IMAGE_WIDTH: csr_prdata = CSR_DATA_BITS'(cfg_ff.image_width);
         CSR_WHITE_LEVEL: csr_prdata = CSR_DATA_BITS'(cfg_ff.white_level);
         CSR_MAX_SPEED:   csr_prdata = CSR_DATA_BITS'(cfg_ff.max_forward_speed);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

[rtl/wbts_tally.sv]
// column tracking and saturating left/mid/right white pixel counters
// depends on wbts_pkg
module wbts_tally
   import wbts_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int COUNT_BITS = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pixel_type             pixel,
   input  cfg_type               cfg,
   output logic [COUNT_BITS-1:0] left_upd,
   output logic [COUNT_BITS-1:0] mid_upd,
   output logic [COUNT_BITS-1:0] right_upd
);

   localparam int EW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = EW + 2;

   logic [CW-1:0]         column_ff, column_in;
   logic [COUNT_BITS-1:0] left_ff, mid_ff, right_ff;
   logic [31:0]           width_ext;
   logic [EW-1:0]         width_eff;
   logic [CMPW-1:0]       col3, col_next, width2, width_cmp;
   logic                  hit, is_left, is_right;

   // effective width: zero acts as one, clamp at the maximum
   assign width_ext = 32'(cfg.image_width);
   always_comb begin
      if (width_ext == 32'd0) begin
         width_eff = EW'(1);
      end else if (width_ext > 32'(MAX_WIDTH)) begin
         width_eff = EW'(MAX_WIDTH);
      end else begin
         width_eff = EW'(width_ext);
      end
   end

   // thirds sort in exact integers
   assign width_cmp = CMPW'(width_eff);
   assign width2    = width_cmp << 1;
   assign col3      = (CMPW'(column_ff) << 1) + CMPW'(column_ff);
   assign is_left   = col3 < width_cmp;
   assign is_right  = col3 > width2;

   assign hit = accept && (pixel.red == cfg.white_level)
                && (pixel.green == cfg.white_level) && (pixel.blue == cfg.white_level);

   // counts including this pixel, saturating
   always_comb begin
      left_upd  = left_ff;
      mid_upd   = mid_ff;
      right_upd = right_ff;
      if (hit) begin
         if (is_left) begin
            if (left_ff != '1) left_upd = left_ff + 1'b1;
         end else if (is_right) begin
            if (right_ff != '1) right_upd = right_ff + 1'b1;
         end else begin
            if (mid_ff != '1) mid_upd = mid_ff + 1'b1;
         end
      end
   end

   // column wraps at the row end
   assign col_next = CMPW'(column_ff) + CMPW'(1);
   assign column_in = (col_next >= width_cmp) ? '0 : CW'(col_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         left_ff   <= '0;
         mid_ff    <= '0;
         right_ff  <= '0;
      end else if (accept) begin
         if (pixel.frame_end) begin
            column_ff <= '0;
            left_ff   <= '0;
            mid_ff    <= '0;
            right_ff  <= '0;
         end else begin
            column_ff <= column_in;
            left_ff   <= left_upd;
            mid_ff    <= mid_upd;
            right_ff  <= right_upd;
         end
      end
   end

endmodule

[rtl/wbts_div.sv]
// shared restoring divider, one quotient bit per cycle, for q1.15 ratios
// depends on wbts_pkg; needs dividend <= divisor, gives floor(dividend*2^15/divisor)
module wbts_div
   import wbts_pkg::*;
#(
   parameter int COUNT_BITS = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] dividend,
   input  logic [COUNT_BITS+1:0] divisor,
   output logic [QUO_BITS-1:0]   quotient,
   output div_status_type        status
);

   localparam int TW = COUNT_BITS + 2;

   logic [TW-1:0]        rem_ff, rem_in, div_ff;
   logic [QUO_BITS-1:0]  quo_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 busy_ff, done_ff;
   logic [TW:0]          cand, diff;
   logic                 qbit, last_step;

   // first step compares the dividend as is, later steps shift the remainder
   assign cand      = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff      = cand - {1'b0, div_ff};
   assign qbit      = cand >= {1'b0, div_ff};
   assign rem_in    = qbit ? diff[TW-1:0] : cand[TW-1:0];
   assign last_step = step_ff == STEP_BITS'(QUO_BITS - 1);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (last_step) busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= TW'(dividend);
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_BITS-2:0], qbit};
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[rtl/white_blob_third_steering.sv]
// White blob steering block, top level.
// Input channel req_*: one rgb pixel per item in raster order, frame_end marks the
// last pixel of a frame. A pixel counts when all three channels equal white_level;
// it adds to the left, mid or right count by the third of the row its column is in.
// Ordinary pixels are taken one per cycle while req_ready is high. The frame-end
// item is counted, then the block runs two ratios through one shared divider and
// a 3/10 scale, in the sequencer states turn go, turn wait, speed go, speed wait,
// scale and done; req_ready stays low from the acceptance of the frame-end item
// until the result is loaded into the output register.
// Result channel rsp_*: one item per frame with linear_speed, turn_rate (q1.15),
// ball_seen and the three counts. The result sits in an output register; pixels of
// the next frame are taken while it waits. If the receiver still holds off the
// previous result when the next one is ready, the block waits with req_ready low.
// Configuration through the csr_* apb-style port: image_width, white_level and
// max_forward_speed at byte addresses 0, 4 and 8.
// Reset (synchronous) clears the column, counts and sequencer and loads the
// register defaults 640, 255 and 6553; no result is pending after reset.
// depends on wbts_pkg, wbts_csr, wbts_tally, wbts_div
module white_blob_third_steering
   import wbts_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int COUNT_BITS = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pixel_type                req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output result_type               rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int TW = COUNT_BITS + 2;
   localparam int LW = COUNT_BITS + 4;

   cfg_type               cfg;
   div_status_type        div_status;
   seq_state_type         state_ff, state_in;
   logic                  accept, frame_done;
   logic [COUNT_BITS-1:0] left_upd, mid_upd, right_upd;
   logic [COUNT_BITS-1:0] snap_left_ff, snap_mid_ff, snap_right_ff;
   logic [TW-1:0]         total;
   logic                  neg, total_zero;
   logic [COUNT_BITS-1:0] turn_diff, dividend;
   logic [QUO_BITS-1:0]   quotient;
   logic                  div_start, sel_turn, turn_take, speed_take, out_load;
   logic                  neg_ff, low_ff;
   logic [LW-1:0]         mid10, total3;
   logic [SPEED_BITS-1:0] mag, speed_clamp, speed_ff, scaled_ff, speed_out;
   logic [TURN_BITS-1:0]  turn_ff;
   logic [SPEED_BITS+17:0] scale_prod;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   assign accept     = req_valid && req_ready;
   assign frame_done = accept && req_data.frame_end;

   wbts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wbts_tally #(
      .MAX_WIDTH  (MAX_WIDTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_tally (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_data),
      .cfg       (cfg),
      .left_upd  (left_upd),
      .mid_upd   (mid_upd),
      .right_upd (right_upd)
   );

   // frame counts held while the drive values are worked out
   always_ff @(posedge clock) begin
      if (frame_done) begin
         snap_left_ff  <= left_upd;
         snap_mid_ff   <= mid_upd;
         snap_right_ff <= right_upd;
      end
   end

   assign total      = TW'(snap_left_ff) + TW'(snap_mid_ff) + TW'(snap_right_ff);
   assign total_zero = total == '0;
   assign neg        = snap_right_ff > snap_left_ff;
   assign turn_diff  = neg ? snap_right_ff - snap_left_ff : snap_left_ff - snap_right_ff;
   assign dividend   = sel_turn ? turn_diff : snap_mid_ff;

   wbts_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (total),
      .quotient (quotient),
      .status   (div_status)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (frame_done) state_in = S_TURN_GO;
         S_TURN_GO:    state_in = S_TURN_WAIT;
         S_TURN_WAIT:  if (div_status.done) state_in = S_SPEED_GO;
         S_SPEED_GO:   state_in = S_SPEED_WAIT;
         S_SPEED_WAIT: if (div_status.done) state_in = S_SCALE;
         S_SCALE:      state_in = S_DONE;
         S_DONE:       if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      sel_turn   = 1'b0;
      turn_take  = 1'b0;
      speed_take = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:       req_ready = 1'b1;
         S_TURN_GO: begin
            div_start = 1'b1;
            sel_turn  = 1'b1;
         end
         S_TURN_WAIT:  turn_take = div_status.done;
         S_SPEED_GO:   div_start = 1'b1;
         S_SPEED_WAIT: speed_take = div_status.done;
         S_SCALE:      out_load = 1'b0;
         S_DONE:       out_load = !rsp_valid_ff || rsp_ready;
         default:      req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // slow-down test: 10*mid < 3*total
   assign mid10  = (LW'(snap_mid_ff) << 3) + (LW'(snap_mid_ff) << 1);
   assign total3 = (LW'(total) << 1) + LW'(total);

   // turn magnitude saturates at 32767, speed clamps at the register
   assign mag         = quotient[QUO_BITS-1] ? SPEED_SAT : quotient[SPEED_BITS-1:0];
   assign speed_clamp = (quotient > QUO_BITS'(cfg.max_forward_speed))
                        ? cfg.max_forward_speed : quotient[SPEED_BITS-1:0];

   always_ff @(posedge clock) begin
      if (sel_turn) begin
         neg_ff <= neg;
      end
      if (state_ff == S_TURN_WAIT) begin
         low_ff <= mid10 < total3;
      end
      if (turn_take) begin
         turn_ff <= neg_ff ? TURN_BITS'(-{1'b0, mag}) : {1'b0, mag};
      end
      if (speed_take) begin
         speed_ff <= speed_clamp;
      end
      if (state_ff == S_SCALE) begin
         scaled_ff <= SPEED_BITS'(scale_prod[SPEED_BITS+17:SCALE_SHIFT]);
      end
   end

   // 3/10 scale by reciprocal multiply
   assign scale_prod = speed_ff * SCALE_MUL;
   assign speed_out  = low_ff ? scaled_ff : speed_ff;

   // result assembly
   always_comb begin
      rsp_in.linear_speed = total_zero ? '0 : speed_out;
      rsp_in.turn_rate    = total_zero ? '0 : turn_ff;
      rsp_in.ball_seen    = !total_zero;
      rsp_in.left_pixels  = CNT_OUT_BITS'(snap_left_ff);
      rsp_in.mid_pixels   = CNT_OUT_BITS'(snap_mid_ff);
      rsp_in.right_pixels = CNT_OUT_BITS'(snap_right_ff);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/wbts_checker.sv]
// port-level checks of the white blob steering block, bound to the top level
// depends on wbts_pkg and assert_macros.svh
`include "assert_macros.svh"

module wbts_checker
   import wbts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input pixel_type  req_data,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input result_type rsp_data
);

   logic rsp_stall;
   logic frame_in;
   logic empty_rsp;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign frame_in  = req_valid && req_ready && req_data.frame_end;
   assign empty_rsp = (rsp_data.linear_speed == '0) && (rsp_data.turn_rate == '0)
                      && (rsp_data.left_pixels == '0) && (rsp_data.mid_pixels == '0)
                      && (rsp_data.right_pixels == '0);

   // a stalled result item holds
   `WBTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // the frame-end item starts the divide sequence, no pixel in the next cycle
   `WBTS_ASSERT_NEXT(a_frame_busy, clock, reset, frame_in, !req_ready)

   // an empty frame drives nothing and reports no counts
   `WBTS_ASSERT_SAME(a_empty, clock, reset, rsp_valid && !rsp_data.ball_seen, empty_rsp)

   // turn magnitude saturates at 32767 both ways
   `WBTS_ASSERT_SAME(a_turn_sat, clock, reset, rsp_valid, rsp_data.turn_rate != 16'h8000)

endmodule

bind white_blob_third_steering wbts_checker u_wbts_checker (.*);

[sim/tb_white_blob_third_steering.sv]
// testbench for white_blob_third_steering: pixel frames in, steering results checked
// against an in-bench model of the thirds counts and the q1.15 drive values
// depends on wbts_pkg and the white_blob_third_steering rtl
`timescale 1ns / 1ps

module tb_white_blob_third_steering;
   import wbts_pkg::*;

   localparam int MAX_COLS      = 4096;
   localparam int COUNT_WIDTH   = 22;
   localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 152;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      bit                    is_write;
      logic [1:0]            reg_index;
      logic [31:0]           reg_value;
      pixel_type             pixel;
      bit                    typed;
      result_type            want;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pixel_type                req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   result_type               rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // model copy of the registers and the frame state
   logic [WIDTH_BITS-1:0]    cfg_width     = WIDTH_RESET;
   logic [LEVEL_BITS-1:0]    cfg_level     = LEVEL_RESET;
   logic [SPEED_BITS-1:0]    cfg_max_speed = SPEED_RESET;
   int unsigned              column_pos    = 0;
   int unsigned              left_count    = 0;
   int unsigned              mid_count     = 0;
   int unsigned              right_count   = 0;

   result_type               frame_results[$];
   directed_row_type         directed_rows[$];
   int                       fail_count    = 0;
   int                       cycle_count   = 0;
   int                       send_idle_pct = 0;
   int                       rcv_idle_pct  = 0;
   int                       hold_left     = 0;
   logic                     hold_off_request;

   white_blob_third_steering #(
      .MAX_WIDTH (MAX_COLS),
      .COUNT_BITS(COUNT_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // row width as the block sees it: zero acts as one, clipped at the maximum
   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_COLS) return MAX_COLS;
      return cfg_width;
   endfunction

   // count one pixel into its third; on frame end queue the steering result
   function automatic void tally_pixel(input pixel_type px);
      int unsigned     w;
      longint unsigned col3;
      longint unsigned total;
      longint unsigned diff;
      longint unsigned mag;
      longint unsigned speed;
      bit              neg;
      result_type      res;
      w = eff_width();
      if (px.red == cfg_level && px.green == cfg_level && px.blue == cfg_level) begin
         col3 = 3 * longint'(column_pos);
         if (col3 < w) begin
            if (left_count < COUNT_MAX) left_count++;
         end else if (col3 > 2 * w) begin
            if (right_count < COUNT_MAX) right_count++;
         end else begin
            if (mid_count < COUNT_MAX) mid_count++;
         end
      end
      if (!px.frame_end) begin
         column_pos = (column_pos + 1 >= w) ? 0 : column_pos + 1;
         return;
      end
      res = '0;
      total = longint'(left_count) + mid_count + right_count;
      if (total != 0) begin
         neg  = right_count > left_count;
         diff = neg ? right_count - left_count : left_count - right_count;
         mag  = (diff << 15) / total;
         if (mag > 32767) mag = 32767;
         res.turn_rate = 16'(mag);
         if (neg) res.turn_rate = -res.turn_rate;
         speed = (longint'(mid_count) << 15) / total;
         if (speed > cfg_max_speed) speed = cfg_max_speed;
         if (10 * longint'(mid_count) < 3 * total) speed = (speed * 3) / 10;
         res.linear_speed = 15'(speed);
         res.ball_seen    = 1'b1;
      end
      res.left_pixels  = 22'(left_count);
      res.mid_pixels   = 22'(mid_count);
      res.right_pixels = 22'(right_count);
      frame_results.push_back(res);
      column_pos  = 0;
      left_count  = 0;
      mid_count   = 0;
      right_count = 0;
   endfunction

   // directed stimulus rows
   function automatic void add_pixel(input logic [7:0] r, g, b, input logic fe);
      directed_row_type row;
      row = '0;
      row.pixel = '{red: r, green: g, blue: b, frame_end: fe};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_frame_check(input logic [7:0] r, g, b,
                                           input int speed, turn, seen, lc, mc, rc);
      directed_row_type row;
      row = '0;
      row.pixel = '{red: r, green: g, blue: b, frame_end: 1'b1};
      row.typed = 1'b1;
      row.want.linear_speed = 15'(speed);
      row.want.turn_rate    = 16'(turn);
      row.want.ball_seen    = 1'(seen);
      row.want.left_pixels  = 22'(lc);
      row.want.mid_pixels   = 22'(mc);
      row.want.right_pixels = 22'(rc);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [1:0] idx, input logic [31:0] value);
      directed_row_type row;
      row = '0;
      row.is_write  = 1'b1;
      row.reg_index = idx;
      row.reg_value = value;
      directed_rows.push_back(row);
   endfunction

   // offer one pixel item, with random idle cycles ahead of it
   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      tally_pixel(px);
   endtask

   // stop sending, wait for every result, then let the block finish any pixel
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup, access, then idle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: cfg_width     = value[WIDTH_BITS-1:0];
         CSR_WHITE_LEVEL: cfg_level     = value[LEVEL_BITS-1:0];
         CSR_MAX_SPEED:   cfg_max_speed = value[SPEED_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // result checker and receiver ready, with the long hold-off on request
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results.size() == 0) begin
            $error("result item with no frame end waiting");
            fail_count++;
         end else begin
            want = frame_results.pop_front();
            check_field("linear_speed", want.linear_speed, rsp_data.linear_speed);
            check_field("turn_rate", $signed(want.turn_rate), $signed(rsp_data.turn_rate));
            check_field("ball_seen", want.ball_seen, rsp_data.ball_seen);
            check_field("left_pixels", want.left_pixels, rsp_data.left_pixels);
            check_field("mid_pixels", want.mid_pixels, rsp_data.mid_pixels);
            check_field("right_pixels", want.right_pixels, rsp_data.right_pixels);
         end
      end
      if (hold_off_request) begin
         hold_left = HOLD_CYCLES;
         hold_off_request <= 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("white_blob_third_steering test failed");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      pixel_type        px;
      int               phase;
      int               sent;
      int               frame_len;
      int               white_pct;
      int unsigned      w;
      logic [31:0]      width_val;
      logic [31:0]      level_val;
      logic [31:0]      speed_val;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      rsp_ready        <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      hold_off_request <= 1'b0;

      // defaults: empty frame, single left pixel, near-white pixels that must not count
      add_frame_check(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_frame_check(255, 255, 255, 0, 32767, 1, 1, 0, 0);
      add_pixel(255, 255, 254, 0);
      add_pixel(254, 255, 255, 0);
      add_pixel(255, 254, 255, 0);
      add_frame_check(255, 255, 255, 0, 32767, 1, 1, 0, 0);
      // width 4: mid pixel clamped at full speed, lone right pixel is a full right turn
      add_write(CSR_IMAGE_WIDTH, 4);
      add_write(CSR_MAX_SPEED, 32767);
      repeat (2) add_pixel(0, 0, 0, 0);
      add_frame_check(255, 255, 255, 32767, 0, 1, 0, 1, 0);
      repeat (3) add_pixel(0, 0, 0, 0);
      add_frame_check(255, 255, 255, 0, -32767, 1, 0, 0, 1);
      // one full white row, speed scaled by 3/10
      repeat (3) add_pixel(255, 255, 255, 0);
      add_pixel(255, 255, 255, 1);
      // width zero acts as one, black counts at level zero, speed clamp zero
      add_write(CSR_IMAGE_WIDTH, 0);
      add_write(CSR_WHITE_LEVEL, 0);
      add_write(CSR_MAX_SPEED, 0);
      add_pixel(0, 0, 0, 0);
      add_frame_check(0, 0, 0, 0, 32767, 1, 2, 0, 0);
      // width above the maximum
      add_write(CSR_IMAGE_WIDTH, 8191);
      add_write(CSR_WHITE_LEVEL, 128);
      add_write(CSR_MAX_SPEED, 6553);
      add_pixel(128, 128, 128, 0);
      add_frame_check(128, 128, 128, 0, 32767, 1, 2, 0, 0);
      // width lowered mid-frame: column past width sorts right, then wraps
      add_write(CSR_IMAGE_WIDTH, 8);
      repeat (3) add_pixel(1, 2, 3, 0);
      add_write(CSR_IMAGE_WIDTH, 1);
      add_pixel(128, 128, 128, 0);
      add_frame_check(128, 128, 128, 0, 0, 1, 1, 0, 1);

      send_idle_pct = 20;
      rcv_idle_pct  = 51;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.is_write) begin
            settle();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_pixel(row.pixel);
            if (row.typed) frame_results[frame_results.size() - 1] = row.want;
         end
      end

      // random frames, new register settings each phase
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       width_val = 1;
            1:       width_val = MAX_COLS;
            2:       width_val = 8191;
            3:       width_val = 3;
            default: width_val = ($urandom_range(3) == 0) ? $urandom_range(13, 300)
                                                           : $urandom_range(2, 12);
         endcase
         case (phase % 3)
            0:       level_val = 0;
            1:       level_val = 255;
            default: level_val = $urandom_range(255);
         endcase
         case (phase % 4)
            0:       speed_val = 32767;
            1:       speed_val = 0;
            default: speed_val = $urandom_range(32767);
         endcase
         write_reg(CSR_IMAGE_WIDTH, width_val);
         write_reg(CSR_WHITE_LEVEL, level_val);
         write_reg(CSR_MAX_SPEED, speed_val);
         if (phase < 4) begin
            send_idle_pct = 20;
            rcv_idle_pct  = 51;
         end else if (phase < 8) begin
            send_idle_pct = 51;
            rcv_idle_pct  = 20;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         // receiver holds off while frames keep coming, so the block backs up
         if (phase == 8) hold_off_request <= 1'b1;
         w = eff_width();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            white_pct = 34 * $urandom_range(3);
            frame_len = $urandom_range(1, (w <= 12) ? 3 * w + 2 : 40);
            for (int i = 0; i < frame_len; i++) begin
               if ($urandom_range(99) < white_pct) begin
                  px.red   = cfg_level;
                  px.green = cfg_level;
                  px.blue  = cfg_level;
               end else if ($urandom_range(1) == 0) begin
                  px.red   = 8'($urandom);
                  px.green = 8'($urandom);
                  px.blue  = 8'($urandom);
               end else begin
                  // one channel off the level
                  px.red   = cfg_level;
                  px.green = cfg_level;
                  px.blue  = cfg_level;
                  case ($urandom_range(2))
                     0:       px.red   = px.red ^ 8'($urandom_range(1, 255));
                     1:       px.green = px.green ^ 8'($urandom_range(1, 255));
                     default: px.blue  = px.blue ^ 8'($urandom_range(1, 255));
                  endcase
               end
               px.frame_end = (i == frame_len - 1);
               send_pixel(px);
               sent++;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("white_blob_third_steering test passed");
      end else begin
         $display("white_blob_third_steering test failed");
      end
      $finish;
   end

endmodule

[white_blob_third_steering.f]
+incdir+rtl
rtl/wbts_pkg.sv
rtl/wbts_csr.sv
rtl/wbts_tally.sv
rtl/wbts_div.sv
rtl/white_blob_third_steering.sv
rtl/wbts_checker.sv
sim/tb_white_blob_third_steering.sv
